### rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked at every rising clock edge outside reset.
`define FNST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define FNST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FNST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fnst_pkg.sv
// Constants and types of the fractional-N synthesizer tuning pipeline.
package fnst_pkg;

  // Field and datapath widths.
  localparam int unsigned TUNE_W     = 31;
  localparam int unsigned LO_W       = 32;
  localparam int unsigned ODIV_W     = 3;
  localparam int unsigned VCO_W      = 35;
  localparam int unsigned NQ_W       = 10;
  localparam int unsigned REM0_W     = 27;
  localparam int unsigned REM_W      = 26;
  localparam int unsigned FRAC_BITS  = 18;
  localparam int unsigned FM_W       = REM_W + FRAC_BITS;
  localparam int unsigned NUM_STAGES = 8;
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned DATA_W     = 32;

  // Frequency plan in hertz.
  localparam logic [TUNE_W-1:0] TUNE_MAX_HZ  = TUNE_W'(1100000000);
  localparam logic [TUNE_W-1:0] THRESH_RESET = TUNE_W'(500000000);
  localparam longint unsigned   IF_HZ        = 64'd908250000;
  localparam longint unsigned   OFFSET_HZ    = 64'd2065;
  localparam longint unsigned   REF_HZ       = 64'd50000000;
  localparam logic [LO_W-1:0]   LO_BASE      = LO_W'(IF_HZ + OFFSET_HZ);

  // Output divider bands on the LO frequency.
  localparam logic [LO_W-1:0] BAND_LOW_HZ = LO_W'(64'd700000000);
  localparam logic [LO_W-1:0] BAND_6_HZ   = LO_W'(64'd1065000000);
  localparam logic [LO_W-1:0] BAND_5_HZ   = LO_W'(64'd1278000000);
  localparam logic [LO_W-1:0] BAND_4_HZ   = LO_W'(64'd1598000000);
  localparam logic [LO_W-1:0] BAND_3_HZ   = LO_W'(64'd2130000000);
  localparam logic [LO_W-1:0] BAND_2_HZ   = LO_W'(64'd3195000000);

  // The reference is 2^7 times an odd factor; the quotient reciprocal works on the odd part.
  localparam int unsigned      REF_SHIFT  = 7;
  localparam longint unsigned  REF_ODD    = REF_HZ >> REF_SHIFT;
  localparam int unsigned      RECIP_K    = 32;
  localparam int unsigned      RECIP_Q_W  = 14;
  localparam logic [RECIP_Q_W-1:0] RECIP_Q = RECIP_Q_W'((64'd1 << RECIP_K) / REF_ODD);

  // Fraction scale and its reciprocal, scaled by 2^REM_W.
  localparam logic [FRAC_BITS-1:0] FRAC_MAX  = {FRAC_BITS{1'b1}};
  localparam int unsigned          RECIP_F_W = FRAC_BITS + 1;
  localparam logic [RECIP_F_W-1:0] RECIP_F   =
      RECIP_F_W'((64'(FRAC_MAX) << REM_W) / REF_HZ);

  // Largest integer feedback divider N.
  localparam logic [NQ_W-1:0] MAX_INT_DIVIDER = NQ_W'(511);

  // Register index decoded from paddr bit 2.
  localparam logic REG_BAND_THRESHOLD = 1'b0;

  typedef struct packed {
    logic                 uhf_select;
    logic [ODIV_W-1:0]    out_divider;
    logic [NQ_W-1:0]      nm1;
    logic [FRAC_BITS-1:0] frac;
  } result_t;

endpackage

### rtl/fnst_datapath.sv
// Eight-stage datapath computing band, dividers and fraction for one request.
module fnst_datapath (
  input  logic                                     clk_i,
  input  logic [fnst_pkg::NUM_STAGES-1:0]          en_i,
  input  logic [fnst_pkg::TUNE_W-1:0]              tune_hz_i,
  input  logic [fnst_pkg::TUNE_W-1:0]              band_threshold_hz_i,
  output fnst_pkg::result_t                        res_o
);

  localparam int unsigned X_W  = fnst_pkg::VCO_W - fnst_pkg::REF_SHIFT;
  localparam int unsigned QP_W = X_W + fnst_pkg::RECIP_Q_W;
  localparam int unsigned FP_W = fnst_pkg::REM_W + fnst_pkg::RECIP_F_W;

  // Stage 0: saturation, LO and band switch.
  logic [fnst_pkg::TUNE_W-1:0] tune_sat;
  logic [fnst_pkg::LO_W-1:0]   lo_d, lo_q;
  logic                        uhf_d, uhf0_q;

  always_comb begin
    tune_sat = (tune_hz_i > fnst_pkg::TUNE_MAX_HZ) ? fnst_pkg::TUNE_MAX_HZ : tune_hz_i;
    lo_d     = fnst_pkg::LO_W'(tune_sat) + fnst_pkg::LO_BASE;
    // LO above IF plus threshold is the same as tune plus offset above threshold.
    uhf_d    = (fnst_pkg::LO_W'(tune_sat) + fnst_pkg::LO_W'(fnst_pkg::OFFSET_HZ)) >
               fnst_pkg::LO_W'(band_threshold_hz_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      lo_q   <= lo_d;
      uhf0_q <= uhf_d;
    end
  end

  // Stage 1: output divider and VCO minus one.
  logic [fnst_pkg::ODIV_W-1:0] odiv_d, odiv1_q;
  logic [fnst_pkg::VCO_W-1:0]  vco, vm1_d, vm1_q;
  logic                        uhf1_q;

  always_comb begin
    if (lo_q > fnst_pkg::BAND_LOW_HZ && lo_q <= fnst_pkg::BAND_6_HZ) begin
      odiv_d = fnst_pkg::ODIV_W'(6);
    end else if (lo_q > fnst_pkg::BAND_6_HZ && lo_q <= fnst_pkg::BAND_5_HZ) begin
      odiv_d = fnst_pkg::ODIV_W'(5);
    end else if (lo_q > fnst_pkg::BAND_5_HZ && lo_q <= fnst_pkg::BAND_4_HZ) begin
      odiv_d = fnst_pkg::ODIV_W'(4);
    end else if (lo_q > fnst_pkg::BAND_4_HZ && lo_q <= fnst_pkg::BAND_3_HZ) begin
      odiv_d = fnst_pkg::ODIV_W'(3);
    end else if (lo_q > fnst_pkg::BAND_3_HZ && lo_q <= fnst_pkg::BAND_2_HZ) begin
      odiv_d = fnst_pkg::ODIV_W'(2);
    end else begin
      odiv_d = fnst_pkg::ODIV_W'(1);
    end
    vco   = fnst_pkg::VCO_W'(lo_q) * fnst_pkg::VCO_W'(odiv_d);
    vm1_d = vco - fnst_pkg::VCO_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      odiv1_q <= odiv_d;
      vm1_q   <= vm1_d;
      uhf1_q  <= uhf0_q;
    end
  end

  // Stage 2: quotient estimate of (VCO-1)/REF, low by at most one.
  logic [X_W-1:0]              qx;
  logic [QP_W-1:0]             qprod;
  logic [fnst_pkg::NQ_W-1:0]   qest_d, qest2_q;
  logic [fnst_pkg::VCO_W-1:0]  vm12_q;
  logic [fnst_pkg::ODIV_W-1:0] odiv2_q;
  logic                        uhf2_q;

  always_comb begin
    qx     = vm1_q[fnst_pkg::VCO_W-1:fnst_pkg::REF_SHIFT];
    qprod  = QP_W'(qx) * QP_W'(fnst_pkg::RECIP_Q);
    qest_d = qprod[fnst_pkg::RECIP_K +: fnst_pkg::NQ_W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      qest2_q <= qest_d;
      vm12_q  <= vm1_q;
      odiv2_q <= odiv1_q;
      uhf2_q  <= uhf1_q;
    end
  end

  // Stage 3: remainder of the estimate.
  logic [fnst_pkg::VCO_W-1:0]  rem0_full;
  logic [fnst_pkg::REM0_W-1:0] rem0_q;
  logic [fnst_pkg::NQ_W-1:0]   qest3_q;
  logic [fnst_pkg::ODIV_W-1:0] odiv3_q;
  logic                        uhf3_q;

  assign rem0_full = vm12_q -
      fnst_pkg::VCO_W'(qest2_q) * fnst_pkg::VCO_W'(fnst_pkg::REF_HZ);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      rem0_q  <= rem0_full[fnst_pkg::REM0_W-1:0];
      qest3_q <= qest2_q;
      odiv3_q <= odiv2_q;
      uhf3_q  <= uhf2_q;
    end
  end

  // Stage 4: quotient correction, N-1, remainder in 1..REF and the cap.
  logic                        qfix;
  logic [fnst_pkg::NQ_W-1:0]   qc, nm1_d, nm14_q;
  logic [fnst_pkg::REM_W-1:0]  rem_d, rem4_q;
  logic                        cap_d, cap4_q;
  logic [fnst_pkg::ODIV_W-1:0] odiv4_q;
  logic                        uhf4_q;

  always_comb begin
    qfix  = rem0_q >= fnst_pkg::REM0_W'(fnst_pkg::REF_HZ);
    qc    = qfix ? (qest3_q + fnst_pkg::NQ_W'(1)) : qest3_q;
    rem_d = qfix ?
        fnst_pkg::REM_W'(rem0_q - fnst_pkg::REM0_W'(fnst_pkg::REF_HZ) + fnst_pkg::REM0_W'(1)) :
        fnst_pkg::REM_W'(rem0_q + fnst_pkg::REM0_W'(1));
    cap_d = qc >= fnst_pkg::MAX_INT_DIVIDER;
    nm1_d = cap_d ? (fnst_pkg::MAX_INT_DIVIDER - fnst_pkg::NQ_W'(1)) : qc;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      nm14_q  <= nm1_d;
      rem4_q  <= rem_d;
      cap4_q  <= cap_d;
      odiv4_q <= odiv3_q;
      uhf4_q  <= uhf3_q;
    end
  end

  // Stage 5: fraction estimate, low by at most one.
  logic [FP_W-1:0]                fprod;
  logic [fnst_pkg::FRAC_BITS-1:0] fest_d, fest5_q;
  logic [fnst_pkg::REM_W-1:0]     rem5_q;
  logic [fnst_pkg::NQ_W-1:0]      nm15_q;
  logic                           cap5_q;
  logic [fnst_pkg::ODIV_W-1:0]    odiv5_q;
  logic                           uhf5_q;

  always_comb begin
    fprod  = FP_W'(rem4_q) * FP_W'(fnst_pkg::RECIP_F);
    fest_d = fprod[fnst_pkg::REM_W +: fnst_pkg::FRAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      fest5_q <= fest_d;
      rem5_q  <= rem4_q;
      nm15_q  <= nm14_q;
      cap5_q  <= cap4_q;
      odiv5_q <= odiv4_q;
      uhf5_q  <= uhf4_q;
    end
  end

  // Stage 6: scaled remainder and the estimate times REF.
  logic [fnst_pkg::FM_W-1:0]      fm_d, fm6_q, fref_d, fref6_q;
  logic [fnst_pkg::FRAC_BITS-1:0] fest6_q;
  logic [fnst_pkg::NQ_W-1:0]      nm16_q;
  logic                           cap6_q;
  logic [fnst_pkg::ODIV_W-1:0]    odiv6_q;
  logic                           uhf6_q;

  always_comb begin
    fm_d   = (fnst_pkg::FM_W'(rem5_q) << fnst_pkg::FRAC_BITS) - fnst_pkg::FM_W'(rem5_q);
    fref_d = fnst_pkg::FM_W'(fest5_q) * fnst_pkg::FM_W'(fnst_pkg::REF_HZ);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      fm6_q   <= fm_d;
      fref6_q <= fref_d;
      fest6_q <= fest5_q;
      nm16_q  <= nm15_q;
      cap6_q  <= cap5_q;
      odiv6_q <= odiv5_q;
      uhf6_q  <= uhf5_q;
    end
  end

  // Stage 7: fraction correction and saturation into the output register.
  logic [fnst_pkg::FM_W-1:0]      fdiff;
  fnst_pkg::result_t              res_d, res_q;

  always_comb begin
    fdiff             = fm6_q - fref6_q;
    res_d.uhf_select  = uhf6_q;
    res_d.out_divider = odiv6_q;
    res_d.nm1         = nm16_q;
    if (cap6_q) begin
      res_d.frac = fnst_pkg::FRAC_MAX;
    end else if (fdiff >= fnst_pkg::FM_W'(fnst_pkg::REF_HZ)) begin
      res_d.frac = fest6_q + fnst_pkg::FRAC_BITS'(1);
    end else begin
      res_d.frac = fest6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### rtl/fractional_n_synth_tuning.sv
// Top level of the fractional-N synthesizer tuning calculator.
//
// A request on the input channel carries a tuned frequency in hertz (tune_hz_i);
// values above 1.1 GHz are clamped. The block adds the 908.25 MHz IF and a
// 2065 Hz offset to get the LO, selects the UHF or VHF antenna path against the
// programmable band threshold, picks the output divider from the LO band and
// returns the integer divider N-1, the 18-bit fraction and their register fields.
// Both channels use valid and stall; a request moves at a clock edge where
// valid is high and stall is low.
// The result is registered in every stage of the pipeline before it appears on
// the output; the throughput is one request per cycle while the receiver does
// not stall, set by the eight-stage pipeline with its two reciprocal
// multiplications and correction steps.
// When the receiver stalls, the result holds on the output and the stages
// behind it keep filling until every stage holds a request; only then does
// in_stall_o rise. Empty stages are squeezed out, so nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets the band
// threshold to 500 MHz. The threshold sits at APB byte address 0 and may only
// be written while no request is in flight.
module fractional_n_synth_tuning (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [fnst_pkg::TUNE_W-1:0]       tune_hz_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              uhf_select_o,
  output logic [2:0]                        out_divider_o,
  output logic [8:0]                        int_divider_o,
  output logic [17:0]                       frac_word_o,
  output logic [5:0]                        frac_high_byte_o,
  output logic [7:0]                        frac_mid_byte_o,
  output logic [3:0]                        frac_low_nibble_o,
  output logic [1:0]                        n_high_bits_o,
  output logic [7:0]                        n_low_byte_o,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fnst_pkg::ADDR_W-1:0]       paddr,
  input  logic [fnst_pkg::DATA_W-1:0]       pwdata,
  output logic [fnst_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  // Band threshold register.
  logic [fnst_pkg::TUNE_W-1:0] thresh_q;
  logic                        reg_sel;
  logic                        reg_wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == fnst_pkg::REG_BAND_THRESHOLD;
  assign reg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? fnst_pkg::DATA_W'(thresh_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= fnst_pkg::THRESH_RESET;
    end else if (reg_wr) begin
      thresh_q <= pwdata[fnst_pkg::TUNE_W-1:0];
    end
  end

  // Valid bits travel with the data. A stage takes a new request when it is
  // empty or when the stage after it is taking its current one.
  logic [fnst_pkg::NUM_STAGES-1:0] valid_q;
  logic [fnst_pkg::NUM_STAGES-1:0] ready;

  always_comb begin
    ready[fnst_pkg::NUM_STAGES-1] = !valid_q[fnst_pkg::NUM_STAGES-1] || !out_stall_i;
    for (int k = fnst_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < fnst_pkg::NUM_STAGES; k++) begin
        if (ready[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[fnst_pkg::NUM_STAGES-1];

  fnst_pkg::result_t res;

  fnst_datapath u_datapath (
    .clk_i               (clk_i),
    .en_i                (ready),
    .tune_hz_i           (tune_hz_i),
    .band_threshold_hz_i (thresh_q),
    .res_o               (res)
  );

  // Register fields of the result.
  assign uhf_select_o      = res.uhf_select;
  assign out_divider_o     = res.out_divider;
  assign int_divider_o     = res.nm1[8:0];
  assign frac_word_o       = res.frac[17:0];
  assign frac_high_byte_o  = res.frac[17:12];
  assign frac_mid_byte_o   = res.frac[11:4];
  assign frac_low_nibble_o = res.frac[3:0];
  assign n_high_bits_o     = res.nm1[9:8];
  assign n_low_byte_o      = res.nm1[7:0];

endmodule

### rtl/fnst_checker.sv
// Port-level checker for the tuning calculator and its bind to the top level.
`include "assert_macros.svh"

module fnst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  out_divider_o,
  input logic [8:0]  int_divider_o,
  input logic [17:0] frac_word_o,
  input logic [5:0]  frac_high_byte_o,
  input logic [7:0]  frac_mid_byte_o,
  input logic [3:0]  frac_low_nibble_o,
  input logic [1:0]  n_high_bits_o,
  input logic [7:0]  n_low_byte_o
);

  // A stalled result stays and keeps its value.
  `FNST_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(frac_word_o) && $stable(int_divider_o) && $stable(out_divider_o), "stalled result changed")

  // The input side can only back up when a full pipeline meets a stalled output.
  `FNST_ASSERT_SAME(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stalled without an output stall")

  // Output divider comes from the fixed band table.
  `FNST_ASSERT_SAME(a_odiv_range, out_valid_o, out_divider_o >= 3'd1 && out_divider_o <= 3'd6, "output divider out of range")

  // Packed register fields agree with the full words.
  `FNST_ASSERT(a_fields, !out_valid_o || (frac_high_byte_o == frac_word_o[17:12] && frac_mid_byte_o == frac_word_o[11:4] && frac_low_nibble_o == frac_word_o[3:0] && n_low_byte_o == int_divider_o[7:0] && n_high_bits_o[0] == int_divider_o[8]), "register fields disagree")

endmodule

bind fractional_n_synth_tuning fnst_checker u_fnst_checker (.*);
